>>> src/height_map_text_parser_assert.svh
// assertion macros for the height map text parser
`ifndef HEIGHT_MAP_TEXT_PARSER_ASSERT_SVH
`define HEIGHT_MAP_TEXT_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define HMTP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("hmtp assertion failed");

// antecedent at one edge implies consequent at the next edge
`define HMTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hmtp assertion failed");

`else

`define HMTP_ASSERT_ALWAYS(label, cond)
`define HMTP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/hmtp_pkg.sv
// package with constants and types of the height map text parser
`default_nettype none

package hmtp_pkg;

    localparam int CountWidth = 13;
    localparam int CoordWidth = 12;
    localparam int HeightWidth = 32;
    localparam int ColorWidth = 24;
    localparam int CharWidth = 8;
    localparam int OutDataWidth = 2 * CoordWidth + HeightWidth + ColorWidth;

    typedef logic [CountWidth-1:0] count_t;
    typedef logic [CharWidth-1:0] char_t;

    localparam count_t MAX_COLUMNS = 13'd4096;
    localparam count_t MAX_ROWS = 13'd4096;

    // configuration register indexes
    localparam logic REG_COLUMN_COUNT = 1'b0;
    localparam logic REG_ROW_COUNT = 1'b1;

    // characters with a meaning of their own
    localparam char_t CHAR_SPACE = 8'h20;
    localparam char_t CHAR_NEWLINE = 8'h0a;
    localparam char_t CHAR_NUL = 8'h00;
    localparam char_t CHAR_MINUS = 8'h2d;
    localparam char_t CHAR_PLUS = 8'h2b;
    localparam char_t CHAR_COMMA = 8'h2c;
    localparam char_t CHAR_ZERO = 8'h30;
    localparam char_t CHAR_NINE = 8'h39;
    localparam char_t CHAR_LOWER_A = 8'h61;
    localparam char_t CHAR_LOWER_F = 8'h66;
    localparam char_t CHAR_UPPER_A = 8'h41;
    localparam char_t CHAR_UPPER_F = 8'h46;

    // result of a hex digit decode
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input char_t c);
        hex_digit_t r;
        char_t      d;
        r = '{valid: 1'b0, value: 4'd0};
        d = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            r = '{valid: 1'b1, value: d[3:0]};
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            d = c - CHAR_LOWER_A + 8'd10;
            r = '{valid: 1'b1, value: d[3:0]};
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            d = c - CHAR_UPPER_A + 8'd10;
            r = '{valid: 1'b1, value: d[3:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/height_map_text_parser.sv
// top level of the height map text parser: characters in, points out
//
//  channel    | direction | transaction                  | tdata / tuser / tlast
//  s_axis     | in        | one text character           | tdata[7:0] text_char
//  m_axis     | out       | one point                    | tdata x,y,height,color; tlast row_end
//  cfg        | in        | register write, no read-back | cfg_index 0 columns, 1 rows
//
// one character is taken per cycle while s_axis_tready is high; a point leaves
// after the character that ends its token, via input register, then result register
// the state update is a single pass: one 32-bit multiply-by-ten add at most
// aresetn is synchronous, active low; it clears the parse state and both valids,
// and sets both count registers to their maximum; a stall on m_axis holds the result
// register, then the input register, and only then drops s_axis_tready
`default_nettype none

module height_map_text_parser (
    input  wire                               aclk,
    input  wire                               aresetn,
    // input stream
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [hmtp_pkg::CharWidth-1:0]    s_axis_tdata,   // [7:0] text_char
    // result stream
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [11:0] point_x, [23:12] point_y, [55:24] height, [79:56] rgb_color
    output logic [hmtp_pkg::OutDataWidth-1:0] m_axis_tdata,
    output logic                              m_axis_tlast,   // row_end
    // configuration writes
    input  wire                               cfg_wr_en,
    input  wire                               cfg_index,
    input  wire  [hmtp_pkg::CountWidth-1:0]   cfg_wr_data
);
    import hmtp_pkg::*;

    // parser phase codes
    localparam logic [2:0] PH_SKIP      = 3'd0;
    localparam logic [2:0] PH_NUM       = 3'd1;
    localparam logic [2:0] PH_NUMTAIL   = 3'd2;
    localparam logic [2:0] PH_PREFIX    = 3'd3;
    localparam logic [2:0] PH_COLOR     = 3'd4;
    localparam logic [2:0] PH_COLORTAIL = 3'd5;

    // configuration registers
    count_t column_count_reg;
    count_t row_count_reg;

    // input register
    logic  in_valid_reg;
    char_t in_char_reg;

    // parse state
    logic [2:0]            phase_reg, phase_next;
    count_t                column_index_reg, column_index_next;
    count_t                row_index_reg, row_index_next;
    logic [HeightWidth-1:0] height_accum_reg, height_accum_next;
    logic                  negative_sign_reg, negative_sign_next;
    logic [ColorWidth-1:0] color_accum_reg, color_accum_next;
    logic [1:0]            prefix_skip_reg, prefix_skip_next;

    // result register
    logic                    m_valid_reg, m_valid_next;
    logic [OutDataWidth-1:0] m_data_reg;
    logic                    m_last_reg;

    logic   out_free;
    logic   consume;
    logic   emit;
    logic   ends_row;
    count_t col_limit;
    count_t row_limit;
    logic   is_space;
    logic   is_eol;
    logic   is_digit;
    char_t  digit;
    hex_digit_t hex;
    logic [HeightWidth-1:0] height_out;

    // the result register frees up when empty or taken this cycle
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign consume       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // limits follow the registers live
    assign col_limit = (column_count_reg < MAX_COLUMNS) ? column_count_reg : MAX_COLUMNS;
    assign row_limit = (row_count_reg < MAX_ROWS) ? row_count_reg : MAX_ROWS;

    assign is_space = (in_char_reg == CHAR_SPACE);
    assign is_eol   = (in_char_reg == CHAR_NEWLINE) || (in_char_reg == CHAR_NUL);
    assign is_digit = (in_char_reg >= CHAR_ZERO) && (in_char_reg <= CHAR_NINE);
    assign digit    = in_char_reg - CHAR_ZERO;
    assign hex      = hex_decode(in_char_reg);

    assign height_out = negative_sign_reg ? (HeightWidth'(0) - height_accum_reg)
                                          : height_accum_reg;

    // one character of state update
    always_comb begin
        phase_next         = phase_reg;
        column_index_next  = column_index_reg;
        row_index_next     = row_index_reg;
        height_accum_next  = height_accum_reg;
        negative_sign_next = negative_sign_reg;
        color_accum_next   = color_accum_reg;
        prefix_skip_next   = prefix_skip_reg;
        emit               = 1'b0;
        ends_row           = 1'b0;

        if (phase_reg == PH_SKIP) begin
            if (is_space) begin
                // nothing between tokens
            end else if (is_eol) begin
                // empty row end: no point
                if (row_index_reg < row_limit) begin
                    row_index_next = row_index_reg + 13'd1;
                end
                column_index_next = '0;
            end else if (row_index_reg < row_limit && column_index_reg < col_limit) begin
                // token start
                height_accum_next  = '0;
                negative_sign_next = 1'b0;
                color_accum_next   = '0;
                prefix_skip_next   = '0;
                priority if (in_char_reg == CHAR_MINUS) begin
                    negative_sign_next = 1'b1;
                    phase_next         = PH_NUM;
                end else if (in_char_reg == CHAR_PLUS) begin
                    phase_next = PH_NUM;
                end else if (is_digit) begin
                    height_accum_next = HeightWidth'(digit[3:0]);
                    phase_next        = PH_NUM;
                end else if (in_char_reg == CHAR_COMMA) begin
                    phase_next = PH_PREFIX;
                end else begin
                    phase_next = PH_NUMTAIL;
                end
            end
        end else if (is_space || is_eol) begin
            // token end: one point
            emit              = 1'b1;
            ends_row          = is_eol;
            column_index_next = column_index_reg + 13'd1;
            phase_next        = PH_SKIP;
            if (is_eol) begin
                if (row_index_reg < row_limit) begin
                    row_index_next = row_index_reg + 13'd1;
                end
                column_index_next = '0;
            end
        end else begin
            unique case (phase_reg)
                PH_NUM: begin
                    priority if (is_digit) begin
                        height_accum_next = (height_accum_reg << 3) + (height_accum_reg << 1)
                                          + HeightWidth'(digit[3:0]);
                    end else if (in_char_reg == CHAR_COMMA) begin
                        phase_next = PH_PREFIX;
                    end else begin
                        phase_next = PH_NUMTAIL;
                    end
                end
                PH_NUMTAIL: begin
                    if (in_char_reg == CHAR_COMMA) begin
                        phase_next = PH_PREFIX;
                    end
                end
                PH_PREFIX: begin
                    // two prefix characters such as 0x
                    if (prefix_skip_reg != 2'd0) begin
                        prefix_skip_next = '0;
                        phase_next       = PH_COLOR;
                    end else begin
                        prefix_skip_next = 2'd1;
                    end
                end
                PH_COLOR: begin
                    if (hex.valid) begin
                        color_accum_next = {color_accum_reg[ColorWidth-5:0], hex.value};
                    end else begin
                        phase_next = PH_COLORTAIL;
                    end
                end
                default: begin
                    // colour tail and unused codes: skip to the terminator
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        if (out_free) begin
            m_valid_next = consume && emit;
        end
    end

    // control and parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg  <= MAX_COLUMNS;
            row_count_reg     <= MAX_ROWS;
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            phase_reg         <= PH_SKIP;
            column_index_reg  <= '0;
            row_index_reg     <= '0;
            height_accum_reg  <= '0;
            negative_sign_reg <= 1'b0;
            color_accum_reg   <= '0;
            prefix_skip_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_COLUMN_COUNT: column_count_reg <= cfg_wr_data;
                    REG_ROW_COUNT:    row_count_reg    <= cfg_wr_data;
                    default:          column_count_reg <= column_count_reg;
                endcase
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            m_valid_reg <= m_valid_next;
            if (consume) begin
                phase_reg         <= phase_next;
                column_index_reg  <= column_index_next;
                row_index_reg     <= row_index_next;
                height_accum_reg  <= height_accum_next;
                negative_sign_reg <= negative_sign_next;
                color_accum_reg   <= color_accum_next;
                prefix_skip_reg   <= prefix_skip_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_char_reg <= s_axis_tdata;
        end
        if (consume && emit) begin
            m_data_reg <= {color_accum_reg, height_out,
                           row_index_reg[CoordWidth-1:0], column_index_reg[CoordWidth-1:0]};
            m_last_reg <= ends_row;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

`include "height_map_text_parser_assert.svh"

    // the prefix counter never holds a finished count
    `HMTP_ASSERT_ALWAYS(a_prefix_range, prefix_skip_reg == 2'd0 || prefix_skip_reg == 2'd1)
    // indexes never run past the hard limits
    `HMTP_ASSERT_ALWAYS(a_index_range, column_index_reg <= MAX_COLUMNS && row_index_reg <= MAX_ROWS)
    // a token end always reaches the result register
    `HMTP_ASSERT_NEXT(a_emit_shows, consume && emit, m_valid_reg)
    // a held character is not dropped while the result side stalls
    `HMTP_ASSERT_NEXT(a_in_hold, in_valid_reg && !out_free, in_valid_reg && $stable(in_char_reg))

endmodule

`default_nettype wire
